// ===== design/vdts_pkg.sv =====
// ---------------------------------------------------------------------------
// vdts_pkg
// Shared types, constants and scroll-address step functions for the video
// dot timing and scroll address block.
// ---------------------------------------------------------------------------
package vdts_pkg;

    localparam int unsigned CoordWidth = 9;
    localparam int unsigned AddrWidth  = 15;
    localparam int unsigned FetchWidth = 14;
    localparam int unsigned InDataWidth  = 8;
    localparam int unsigned OutDataWidth = 72;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 15;

    // Register indexes of the configuration port
    localparam logic [CfgIndexWidth-1:0] CFG_NMI_ENABLE   = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_RENDER_EN    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_SCROLL_TEMP  = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_MIRROR_HORIZ = 2'd3;

    // Timing points
    localparam logic [CoordWidth-1:0] DOT_LAST        = 9'd340;
    localparam logic [CoordWidth-1:0] DOT_LAST_FETCH  = 9'd339;
    localparam logic [CoordWidth-1:0] DOT_Y_STEP      = 9'd256;
    localparam logic [CoordWidth-1:0] DOT_HORIZ_COPY  = 9'd257;
    localparam logic [CoordWidth-1:0] DOT_PREFETCH_A  = 9'd321;
    localparam logic [CoordWidth-1:0] DOT_PREFETCH_B  = 9'd323;
    localparam logic [CoordWidth-1:0] DOT_PRE_LOAD    = 9'd280;
    localparam logic [CoordWidth-1:0] DOT_PRE_STEP    = 9'd285;
    localparam logic [CoordWidth-1:0] DOT_FRAME_DONE  = 9'd2;
    localparam logic [CoordWidth-1:0] DOT_VBLANK_EDGE = 9'd1;
    localparam logic [CoordWidth-1:0] LINE_LAST_VIS   = 9'd239;
    localparam logic [CoordWidth-1:0] LINE_POST       = 9'd240;
    localparam logic [CoordWidth-1:0] LINE_VBLANK_SET = 9'd241;
    localparam logic [CoordWidth-1:0] LINE_VBLANK_CLR = 9'd260;
    localparam logic [CoordWidth-1:0] LINE_PRE        = 9'd261;

    // Address masks and fetch bases
    localparam logic [AddrWidth-1:0]  HORIZ_MASK   = 15'h041f;
    localparam logic [AddrWidth-1:0]  KEEP_VERT    = 15'h7be0;
    localparam logic [AddrWidth-1:0]  NT_X_TOGGLE  = 15'h0400;
    localparam logic [AddrWidth-1:0]  NT_Y_TOGGLE  = 15'h0800;
    localparam logic [FetchWidth-1:0] NT_BASE_LO   = 14'h2000;
    localparam logic [FetchWidth-1:0] NT_BASE_HI   = 14'h2400;
    localparam logic [FetchWidth-1:0] AT_BASE_LO   = 14'h23c0;
    localparam logic [FetchWidth-1:0] AT_BASE_HI   = 14'h27c0;

    typedef struct packed {
        logic                 nmi_enable;
        logic                 render_enable;
        logic [AddrWidth-1:0] scroll_temp;
        logic                 mirror_horizontal;
    } cfg_t;

    typedef struct packed {
        logic                  sprite_addr_clear;
        logic [FetchWidth-1:0] attribute_addr;
        logic [FetchWidth-1:0] nametable_addr;
        logic                  fetch_valid;
        logic                  frame_done;
        logic                  nmi_pulse;
        logic                  vblank;
        logic [AddrWidth-1:0]  vram_address;
        logic [CoordWidth-1:0] line_now;
        logic [CoordWidth-1:0] dot_now;
    } result_t;

    // Coarse X: wrap at 31 and flip the horizontal nametable bit
    function automatic logic [AddrWidth-1:0] step_coarse_x(input logic [AddrWidth-1:0] v);
        logic [AddrWidth-1:0] r;
        if (v[4:0] == 5'd31) begin
            r = {v[14:5], 5'd0} ^ NT_X_TOGGLE;
        end else begin
            r = v + 15'd1;
        end
        return r;
    endfunction

    // Fine Y, then coarse Y; row 29 wraps with a vertical table flip, row 31 wraps plain
    function automatic logic [AddrWidth-1:0] step_y(input logic [AddrWidth-1:0] v);
        logic [AddrWidth-1:0] r;
        r = v;
        if (v[14:12] != 3'd7) begin
            r[14:12] = v[14:12] + 3'd1;
        end else begin
            r[14:12] = 3'd0;
            if (v[9:5] == 5'd29) begin
                r[9:5] = 5'd0;
                r      = r ^ NT_Y_TOGGLE;
            end else if (v[9:5] == 5'd31) begin
                r[9:5] = 5'd0;
            end else begin
                r[9:5] = v[9:5] + 5'd1;
            end
        end
        return r;
    endfunction

endpackage

// ===== design/vdts_core.sv =====
// ---------------------------------------------------------------------------
// vdts_core
// Dot/line counters, loopy scroll address and vblank flag, with the result
// of each tick worked out in one pass from the current state.
// ---------------------------------------------------------------------------
module vdts_core import vdts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_fire,
    input  logic    advance,
    input  cfg_t    cfg,
    output result_t result
);

    logic [CoordWidth-1:0] dot_reg, dot_next;
    logic [CoordWidth-1:0] line_reg, line_next;
    logic [AddrWidth-1:0]  vram_reg, vram_next;
    logic                  vblank_reg, vblank_next;
    logic                  nmi, frame, fetch, sclr, hi_table;

    always_comb begin
        dot_next    = dot_reg;
        line_next   = line_reg;
        vram_next   = vram_reg;
        vblank_next = vblank_reg;
        nmi   = 1'b0;
        frame = 1'b0;
        fetch = 1'b0;
        sclr  = 1'b0;
        if (advance) begin
            priority if (line_reg <= LINE_LAST_VIS && dot_reg <= DOT_LAST_FETCH) begin
                if (cfg.render_enable) begin
                    if (dot_reg >= 9'd1 && dot_reg <= DOT_Y_STEP) begin
                        if (dot_reg[2:0] == 3'd0 && dot_reg < DOT_Y_STEP) begin
                            vram_next = step_coarse_x(vram_reg);
                            fetch     = 1'b1;
                        end else if (dot_reg == DOT_Y_STEP) begin
                            vram_next = step_y(vram_reg);
                        end
                    end else if (dot_reg == DOT_HORIZ_COPY) begin
                        vram_next = (vram_reg & KEEP_VERT) | (cfg.scroll_temp & HORIZ_MASK);
                        sclr      = 1'b1;
                    end else if (dot_reg == DOT_PREFETCH_A) begin
                        fetch = 1'b1;
                    end else if (dot_reg == DOT_PREFETCH_B) begin
                        vram_next = step_coarse_x(vram_reg);
                        fetch     = 1'b1;
                    end
                end
                dot_next = dot_reg + 9'd1;
            end else if (line_reg <= LINE_VBLANK_CLR && dot_reg >= DOT_LAST) begin
                dot_next  = '0;
                line_next = line_reg + 9'd1;
            end else if (line_reg >= LINE_PRE) begin
                if (dot_reg < DOT_LAST) begin
                    if (cfg.render_enable && dot_reg == DOT_PRE_LOAD) begin
                        vram_next = cfg.scroll_temp;
                        fetch     = 1'b1;
                    end else if (cfg.render_enable && dot_reg == DOT_PRE_STEP) begin
                        vram_next = step_coarse_x(vram_reg);
                        fetch     = 1'b1;
                    end
                    dot_next = dot_reg + 9'd1;
                end else begin
                    dot_next  = '0;
                    line_next = '0;
                end
            end else if (line_reg == LINE_POST) begin
                frame    = (dot_reg == DOT_FRAME_DONE);
                dot_next = dot_reg + 9'd1;
            end else begin
                if (line_reg == LINE_VBLANK_SET && dot_reg == DOT_VBLANK_EDGE) begin
                    vblank_next = 1'b1;
                    nmi         = cfg.nmi_enable;
                end else if (line_reg == LINE_VBLANK_CLR && dot_reg == DOT_VBLANK_EDGE) begin
                    vblank_next = 1'b0;
                end
                dot_next = dot_reg + 9'd1;
            end
        end
    end

    // Mirroring picks which address bit chooses the upper table
    assign hi_table = cfg.mirror_horizontal ? vram_next[10] : vram_next[11];

    always_comb begin
        result.dot_now           = dot_next;
        result.line_now          = line_next;
        result.vram_address      = vram_next;
        result.vblank            = vblank_next;
        result.nmi_pulse         = nmi;
        result.frame_done        = frame;
        result.fetch_valid       = fetch;
        result.sprite_addr_clear = sclr;
        result.nametable_addr    = '0;
        result.attribute_addr    = '0;
        if (fetch) begin
            result.nametable_addr = (hi_table ? NT_BASE_HI : NT_BASE_LO)
                                  + {4'd0, vram_next[9:0]};
            result.attribute_addr = (hi_table ? AT_BASE_HI : AT_BASE_LO)
                                  + {8'd0, vram_next[9:7], vram_next[4:2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg    <= '0;
            line_reg   <= '0;
            vram_reg   <= '0;
            vblank_reg <= 1'b0;
        end else if (item_fire) begin
            dot_reg    <= dot_next;
            line_reg   <= line_next;
            vram_reg   <= vram_next;
            vblank_reg <= vblank_next;
        end
    end

    a_fetch_needs_render: assert property (@(posedge aclk) disable iff (!aresetn)
        result.fetch_valid |-> (advance && cfg.render_enable))
        else $error("tile fetch issued with rendering disabled");

    a_nmi_at_vblank_start: assert property (@(posedge aclk) disable iff (!aresetn)
        result.nmi_pulse |-> (result.vblank && line_reg == LINE_VBLANK_SET))
        else $error("nmi pulse away from vblank start");

    a_sprite_clear_point: assert property (@(posedge aclk) disable iff (!aresetn)
        result.sprite_addr_clear |-> (result.dot_now == 9'd258 && line_reg <= LINE_LAST_VIS))
        else $error("sprite address clear at wrong dot");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (dot_reg <= DOT_LAST && line_reg <= LINE_PRE))
        else $error("dot or line counter out of range");

    a_hold_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_fire && !advance) |=> ($stable(dot_reg) && $stable(vram_reg)))
        else $error("state moved on a hold tick");

endmodule

// ===== design/vdts_out_reg.sv =====
// ---------------------------------------------------------------------------
// vdts_out_reg
// Result register toward the output stream; frees itself when the sink
// takes the result, so a new one can load in the same cycle.
// ---------------------------------------------------------------------------
module vdts_out_reg import vdts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

// ===== design/video_dot_timing_scroll_address.sv =====
// ---------------------------------------------------------------------------
// video_dot_timing_scroll_address
// Video dot timing with loopy scroll address: one tick request in, one
// result request out with position, scroll address, flags and fetch addresses.
// ---------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | s_tdata[0] advance
//  m_axis    | out       | m_tdata: position, scroll address, pulses, fetch addresses
//  cfg       | in        | cfg_index 0 nmi_enable, 1 render_enable,
//            |           |           2 scroll_temp, 3 mirror_horizontal
//
// One tick request per cycle, sustained while m_tready does not stall; each
// accepted request is held in the input register, then its result loads into
// the result register, which drives m_tvalid toward the sink.
// The input register and the result register each free up in the cycle the
// downstream side takes their contents, so stalls on m_tready back up without
// bubbles; s_tready follows m_tready combinationally.
// aresetn (synchronous) clears counters, scroll address, vblank, config and
// valid flags.
// ---------------------------------------------------------------------------
module video_dot_timing_scroll_address import vdts_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [InDataWidth-1:0]   s_tdata,   // [0] advance, [7:1] zero
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [8:0] dot_now, [17:9] line_now, [32:18] vram_address, [33] vblank,
    // [34] nmi_pulse, [35] frame_done, [36] fetch_valid, [50:37] nametable_addr,
    // [64:51] attribute_addr, [65] sprite_addr_clear, [71:66] zero
    output logic [OutDataWidth-1:0]  m_tdata,
    input  logic                     cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata
);

    logic    in_valid_reg, in_valid_next;
    logic    advance_reg;
    logic    core_fire, out_can_load;
    cfg_t    cfg_reg;
    result_t core_result, out_result;

    // Configuration registers: the user must write them only while the stream is idle; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NMI_ENABLE:   cfg_reg.nmi_enable        <= cfg_wdata[0];
                CFG_RENDER_EN:    cfg_reg.render_enable     <= cfg_wdata[0];
                CFG_SCROLL_TEMP:  cfg_reg.scroll_temp       <= cfg_wdata;
                CFG_MIRROR_HORIZ: cfg_reg.mirror_horizontal <= cfg_wdata[0];
                default:          cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Input register: advance into the core whenever the result register can load
    assign core_fire     = in_valid_reg && out_can_load;
    assign s_tready      = !in_valid_reg || out_can_load;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !out_can_load);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            advance_reg <= s_tdata[0];
        end
    end

    vdts_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (core_fire),
        .advance   (advance_reg),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    vdts_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (core_fire),
        .result     (core_result),
        .can_load   (out_can_load),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // Pack the result, dot_now in the low bits, zero pad on top
    assign m_tdata = {6'd0, out_result};

endmodule
